// ===== src/rmv_pkg.sv =====
// Package for the running mean / variance unit: control word types,
// microcode step names and the microprogram table. No dependencies.
package rmv_pkg;

  localparam int DEF_COUNT_WIDTH  = 16;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int FRAC_W  = 16;
  localparam int MEAN_W  = 32;
  localparam int VAR_W   = 48;
  localparam int SUM_W   = 64;
  localparam int OUT_CNT_W = 16;
  localparam int LOOP_W  = 6;
  localparam int STEP_W  = 4;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [LOOP_W-1:0] loop_cnt_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_ACCEPT, OP_DELTA1, OP_DIV_LOAD_MEAN, OP_DIV_STEP, OP_MEAN,
    OP_DELTA2, OP_MUL_LOAD, OP_MUL_STEP, OP_ACCUM, OP_DIV_LOAD_SUM, OP_VAR,
    OP_FIRST, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {WAIT_NONE, WAIT_IN, WAIT_OUT} wait_t;
  typedef enum logic [1:0] {JC_NONE, JC_ALWAYS, JC_FIRST, JC_LOOP} jump_t;
  typedef enum logic [1:0] {LD_NONE, LD_MAG, LD_SUM} loop_ld_t;

  typedef struct packed {
    op_t      op;
    wait_t    wt;
    jump_t    jc;
    step_t    target;
    loop_ld_t ld;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic first;
  } seq_status_t;

  // Microprogram addresses
  localparam step_t S_ACCEPT   = 4'd0;
  localparam step_t S_DELTA1   = 4'd1;
  localparam step_t S_DIV1_LD  = 4'd2;
  localparam step_t S_DIV1     = 4'd3;
  localparam step_t S_MEAN     = 4'd4;
  localparam step_t S_DELTA2   = 4'd5;
  localparam step_t S_MUL_LD   = 4'd6;
  localparam step_t S_MUL      = 4'd7;
  localparam step_t S_ACCUM    = 4'd8;
  localparam step_t S_DIV2_LD  = 4'd9;
  localparam step_t S_DIV2     = 4'd10;
  localparam step_t S_VAR      = 4'd11;
  localparam step_t S_FIRST    = 4'd12;
  localparam step_t S_EMIT     = 4'd13;

  // Magnitude width of the Q16.16 differences
  function automatic int mag_width(int sample_width);
    int xw;
    xw = (sample_width + FRAC_W > MEAN_W) ? sample_width + FRAC_W : MEAN_W;
    return xw + 1;
  endfunction

  function automatic ctrl_t ucode_rom(step_t addr);
    ctrl_t c;
    c = '{op: OP_NOP, wt: WAIT_NONE, jc: JC_ALWAYS, target: S_ACCEPT, ld: LD_NONE};
    unique case (addr)
      S_ACCEPT:  c = '{OP_ACCEPT,       WAIT_IN,   JC_NONE,   S_ACCEPT, LD_NONE};
      S_DELTA1:  c = '{OP_DELTA1,       WAIT_NONE, JC_FIRST,  S_FIRST,  LD_NONE};
      S_DIV1_LD: c = '{OP_DIV_LOAD_MEAN, WAIT_NONE, JC_NONE,  S_ACCEPT, LD_MAG};
      S_DIV1:    c = '{OP_DIV_STEP,     WAIT_NONE, JC_LOOP,   S_DIV1,   LD_NONE};
      S_MEAN:    c = '{OP_MEAN,         WAIT_NONE, JC_NONE,   S_ACCEPT, LD_NONE};
      S_DELTA2:  c = '{OP_DELTA2,       WAIT_NONE, JC_NONE,   S_ACCEPT, LD_NONE};
      S_MUL_LD:  c = '{OP_MUL_LOAD,     WAIT_NONE, JC_NONE,   S_ACCEPT, LD_MAG};
      S_MUL:     c = '{OP_MUL_STEP,     WAIT_NONE, JC_LOOP,   S_MUL,    LD_NONE};
      S_ACCUM:   c = '{OP_ACCUM,        WAIT_NONE, JC_NONE,   S_ACCEPT, LD_NONE};
      S_DIV2_LD: c = '{OP_DIV_LOAD_SUM, WAIT_NONE, JC_NONE,   S_ACCEPT, LD_SUM};
      S_DIV2:    c = '{OP_DIV_STEP,     WAIT_NONE, JC_LOOP,   S_DIV2,   LD_NONE};
      S_VAR:     c = '{OP_VAR,          WAIT_NONE, JC_ALWAYS, S_EMIT,   LD_NONE};
      S_FIRST:   c = '{OP_FIRST,        WAIT_NONE, JC_NONE,   S_ACCEPT, LD_NONE};
      S_EMIT:    c = '{OP_EMIT,         WAIT_OUT,  JC_ALWAYS, S_ACCEPT, LD_NONE};
      default:   c = '{OP_NOP,          WAIT_NONE, JC_ALWAYS, S_ACCEPT, LD_NONE};
    endcase
    return c;
  endfunction

endpackage

// ===== src/running_mean_variance_unit.sv =====
// Running mean / sample variance unit (Welford update): microcode sequencer,
// datapath and output register. Depends on rmv_pkg, rmv_sequencer, rmv_datapath.
//
// Input channel: sample with in_valid / in_stall. One word per sample.
// Output channel: mean_value (Q16.16), variance_value (Q32.16), samples_seen,
// with out_valid / out_stall. One result word per sample, in order.
// Timing: one sample at a time. With M = max(SAMPLE_WIDTH+16, 32) + 1, the
// 64-step serial division of the sum by count-1 dominates, followed by the
// M-step division of the mean difference and the M-step shift-add multiply.
// The first sample after reset skips these and goes from the first difference
// step to the first-sample step. A new sample is taken as soon as the last
// result is loaded into the output register, while that result may still be
// waiting.
// Reset (synchronous): count, mean and sum clear, output word is dropped.
// Stall on the output holds the result word; the sequencer waits at its
// final step until the output register is free.
module running_mean_variance_unit
  import rmv_pkg::*;
#(
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [SAMPLE_WIDTH-1:0]  sample,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic [MEAN_W-1:0]        mean_value,
  output logic [VAR_W-1:0]         variance_value,
  output logic [OUT_CNT_W-1:0]     samples_seen,
  output logic                     out_valid,
  input  logic                     out_stall
);

  ctrl_t                    ctrl;
  logic                     step_go;
  seq_status_t              status;
  logic signed [MEAN_W-1:0] running_mean;
  logic [VAR_W-1:0]         variance;
  logic [COUNT_WIDTH-1:0]   sample_count;
  logic                     first;
  logic                     emit;

  assign status.in_valid = in_valid;
  assign status.out_free = !out_valid || !out_stall;
  assign status.first    = first;
  assign in_stall        = (ctrl.op != OP_ACCEPT);
  assign emit            = (ctrl.op == OP_EMIT) && step_go;

  rmv_sequencer #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .status  (status),
    .ctrl    (ctrl),
    .step_go (step_go)
  );

  rmv_datapath #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .step_go      (step_go),
    .sample       (sample),
    .running_mean (running_mean),
    .variance     (variance),
    .sample_count (sample_count),
    .first        (first)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mean_value     <= running_mean;
      variance_value <= variance;
      samples_seen   <= OUT_CNT_W'(sample_count);
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted word starts the first difference step
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (ctrl.op == OP_DELTA1))
    else $error("accepted sample did not start the update");

  // A new result word only ever comes from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.op == OP_EMIT))
    else $error("output word appeared outside the emit step");

  // First sample after reset gives zero variance
  a_first_var: assert property (@(posedge clk) disable iff (rst)
    (emit && first) |=> (variance_value == '0))
    else $error("first sample gave non-zero variance");
`endif

endmodule

// ===== src/rmv_sequencer.sv =====
// Microcode sequencer: step counter, loop counter and control word fetch.
// Depends on rmv_pkg (control word types and microprogram table).
module rmv_sequencer
  import rmv_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ctrl_t       ctrl,
  output logic        step_go
);

  localparam int MW = mag_width(SAMPLE_WIDTH);
  localparam loop_cnt_t LOOP_MAG = LOOP_W'(MW - 1);
  localparam loop_cnt_t LOOP_SUM = LOOP_W'(SUM_W - 1);

  step_t     pc, pc_next;
  loop_cnt_t loop_cnt, loop_cnt_next;
  logic      taken;

  assign ctrl = ucode_rom(pc);

  always_comb begin
    step_go = !((ctrl.wt == WAIT_IN) && !status.in_valid) &&
              !((ctrl.wt == WAIT_OUT) && !status.out_free);
    unique case (ctrl.jc)
      JC_NONE:   taken = 1'b0;
      JC_ALWAYS: taken = 1'b1;
      JC_FIRST:  taken = status.first;
      JC_LOOP:   taken = (loop_cnt != '0);
      default:   taken = 1'b0;
    endcase

    pc_next       = pc;
    loop_cnt_next = loop_cnt;
    if (step_go) begin
      pc_next = taken ? ctrl.target : pc + 1'b1;
      unique case (ctrl.ld)
        LD_MAG:  loop_cnt_next = LOOP_MAG;
        LD_SUM:  loop_cnt_next = LOOP_SUM;
        default: begin
          if (ctrl.jc == JC_LOOP && loop_cnt != '0) loop_cnt_next = loop_cnt - 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= S_ACCEPT;
      loop_cnt <= '0;
    end else begin
      pc       <= pc_next;
      loop_cnt <= loop_cnt_next;
    end
  end

endmodule

// ===== src/rmv_datapath.sv =====
// Datapath: sample count, running mean, sum of squared deviations, a shared
// restoring divider and a shift-add multiplier. Depends on rmv_pkg.
module rmv_datapath
  import rmv_pkg::*;
#(
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_t                    ctrl,
  input  logic                     step_go,
  input  logic [SAMPLE_WIDTH-1:0]  sample,
  output logic signed [MEAN_W-1:0] running_mean,
  output logic [VAR_W-1:0]         variance,
  output logic [COUNT_WIDTH-1:0]   sample_count,
  output logic                     first
);

  localparam int MW = mag_width(SAMPLE_WIDTH);
  localparam int XW = MW - 1;
  localparam int PW = 2 * MW;
  localparam int DIV_ALIGN = SUM_W - MW;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic signed [MW-1:0]           d1, d2;
  logic [SUM_W-1:0]               sum_sq_dev;
  logic [COUNT_WIDTH-1:0]         rem, divisor;
  logic [SUM_W-1:0]               dq;
  logic [MW-1:0]                  mcand;
  logic [PW-1:0]                  prod;
  logic                           skip;

  logic signed [XW-1:0]    x;
  logic [COUNT_WIDTH-1:0]  count_next;
  logic [MW-1:0]           d1_mag, d2_mag;
  logic [COUNT_WIDTH:0]    rs;
  logic                    ge;
  logic signed [MW:0]      qs, m_wide;
  logic signed [MEAN_W-1:0] m_sat, x_sat;
  logic [MW:0]             mul_sum;
  logic [127:0]            p_ext;
  logic [SUM_W-1:0]        term;
  logic [SUM_W:0]          acc;

  always_comb begin
    x          = XW'(sample_r) <<< FRAC_W;
    count_next = (sample_count != CNT_MAX) ? sample_count + 1'b1 : sample_count;
    d1_mag     = d1[MW-1] ? MW'(-d1) : MW'(d1);
    d2_mag     = d2[MW-1] ? MW'(-d2) : MW'(d2);

    rs = {rem, dq[SUM_W-1]};
    ge = (rs >= {1'b0, divisor});

    // step = +/- truncated quotient, mean clamps to the signed 32-bit range
    qs     = signed'({1'b0, dq[MW-1:0]});
    m_wide = (MW+1)'(running_mean) + (d1[MW-1] ? -qs : qs);
    if ((&m_wide[MW:MEAN_W-1]) || !(|m_wide[MW:MEAN_W-1]))
      m_sat = m_wide[MEAN_W-1:0];
    else
      m_sat = m_wide[MW] ? {1'b1, {(MEAN_W-1){1'b0}}} : {1'b0, {(MEAN_W-1){1'b1}}};

    if ((&x[XW-1:MEAN_W-1]) || !(|x[XW-1:MEAN_W-1]))
      x_sat = x[MEAN_W-1:0];
    else
      x_sat = x[XW-1] ? {1'b1, {(MEAN_W-1){1'b0}}} : {1'b0, {(MEAN_W-1){1'b1}}};

    mul_sum = (MW+1)'(prod[PW-1:MW]) + (prod[0] ? (MW+1)'(mcand) : '0);

    // Q32.32 product down to Q48.16, saturating
    p_ext = 128'(prod);
    if (skip)
      term = '0;
    else if (|p_ext[127:SUM_W+FRAC_W])
      term = '1;
    else
      term = p_ext[SUM_W+FRAC_W-1:FRAC_W];
    acc = {1'b0, sum_sq_dev} + {1'b0, term};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_mean <= '0;
      sum_sq_dev   <= '0;
      first        <= 1'b0;
    end else if (step_go) begin
      unique case (ctrl.op)
        OP_ACCEPT: begin
          sample_count <= count_next;
          first        <= (count_next == COUNT_WIDTH'(1));
        end
        OP_MEAN:  running_mean <= m_sat;
        OP_ACCUM: sum_sq_dev   <= acc[SUM_W] ? '1 : acc[SUM_W-1:0];
        OP_FIRST: begin
          running_mean <= x_sat;
          sum_sq_dev   <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    if (step_go) begin
      unique case (ctrl.op)
        OP_ACCEPT: sample_r <= sample;
        OP_DELTA1: d1 <= MW'(x) - MW'(running_mean);
        OP_DIV_LOAD_MEAN: begin
          dq      <= SUM_W'(d1_mag) << DIV_ALIGN;
          rem     <= '0;
          divisor <= sample_count;
        end
        OP_DIV_STEP: begin
          rem <= ge ? COUNT_WIDTH'(rs - {1'b0, divisor}) : COUNT_WIDTH'(rs);
          dq  <= {dq[SUM_W-2:0], ge};
        end
        OP_DELTA2: d2 <= MW'(x) - MW'(running_mean);
        OP_MUL_LOAD: begin
          mcand <= d1_mag;
          prod  <= {{MW{1'b0}}, d2_mag};
          skip  <= (d1[MW-1] && !d2[MW-1] && |d2) || (d2[MW-1] && !d1[MW-1] && |d1);
        end
        OP_MUL_STEP: prod <= {mul_sum, prod[MW-1:1]};
        OP_DIV_LOAD_SUM: begin
          dq      <= sum_sq_dev;
          rem     <= '0;
          divisor <= sample_count - COUNT_WIDTH'(1);
        end
        OP_VAR:   variance <= (|dq[SUM_W-1:VAR_W]) ? '1 : dq[VAR_W-1:0];
        OP_FIRST: variance <= '0;
        default: ;
      endcase
    end
  end

endmodule
